FILE: rtl/rdik_pkg.sv
// Shared types, constants and helper functions of the rotary delta kinematics block.
package rdik_pkg;

  localparam int TOWERS    = 3;
  localparam int Q_DEPTH   = 2;
  localparam int IN_W      = 21;
  localparam int STEP_W    = 24;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int R_W       = 26;
  localparam int H_W       = 22;
  localparam int SQ_W      = 48;
  localparam int E_W       = 48;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPD    = 3'd5;

  // 180/pi in Q24
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  typedef struct packed {
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic        [15:0] arm;
    logic signed [15:0] bh;
    logic        [15:0] rod;
    logic        [15:0] spd;
  } rdik_twr_cfg_t;

  typedef rdik_twr_cfg_t [TOWERS-1:0] rdik_twr_cfg_all_t;

  typedef struct packed {
    logic signed [R_W-1:0]  r;
    logic signed [H_W-1:0]  h;
    logic        [SQ_W-1:0] d;
    logic signed [E_W-1:0]  e;
  } rdik_twr_job_t;

  typedef rdik_twr_job_t [TOWERS-1:0] rdik_job_t;

  typedef struct packed {
    logic start;
    logic ack;
  } rdik_lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic unreach;
  } rdik_lane_sts_t;

  typedef enum logic [4:0] {
    L_IDLE, L_PREP, L_DIV1, L_CP, L_DISC, L_SQ1, L_SQ1F, L_NMUL, L_NCALC,
    L_DIV2, L_SRND, L_SSQ, L_SINIT, L_SQ2, L_CINIT, L_CORD, L_DEGM, L_DEGR,
    L_STPM, L_STPR, L_DONE
  } rdik_lane_state_t;

  // arctan(2^-i) in Q30 radians
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [30:0] tail;
    tail = (31'd1 << (5'd30 - i)) - 31'd1;
    case (i)
      5'd0:    return 30'd843314856;
      5'd1:    return 30'd497837829;
      5'd2:    return 30'd263043836;
      5'd3:    return 30'd133525158;
      5'd4:    return 30'd67021686;
      5'd5:    return 30'd33543515;
      5'd6:    return 30'd16775850;
      5'd7:    return 30'd8388437;
      5'd8:    return 30'd4194282;
      5'd9:    return 30'd2097149;
      default: return tail[29:0];
    endcase
  endfunction

  // shift right by n, round to nearest with ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input logic [5:0] n);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (n - 6'd1))) >> n;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: rtl/rdik_front.sv
// Front pipeline: accept a point, rotate it per tower and form the squared terms.
module rdik_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rdik_pkg::IN_W-1:0]  x_coord,
  input  logic signed [rdik_pkg::IN_W-1:0]  y_coord,
  input  logic signed [rdik_pkg::IN_W-1:0]  z_coord,
  input  logic        [15:0]                radius,
  input  rdik_pkg::rdik_twr_cfg_all_t       twr_cfg,
  output logic                              push,
  output rdik_pkg::rdik_job_t               job,
  input  logic                              q_full
);
  import rdik_pkg::*;

  localparam int P_W = 37;
  localparam int S_W = 38;

  logic [3:0] vld_r, vld_nxt;
  logic       adv;

  logic signed [P_W-1:0]  pxc_r [TOWERS];
  logic signed [P_W-1:0]  pys_r [TOWERS];
  logic signed [P_W-1:0]  pyc_r [TOWERS];
  logic signed [P_W-1:0]  pxs_r [TOWERS];
  logic signed [IN_W-1:0] z1_r;

  logic signed [R_W-1:0]  r2_r  [TOWERS];
  logic signed [H_W-1:0]  h2_r  [TOWERS];
  logic signed [23:0]     yt2_r [TOWERS];

  logic signed [R_W-1:0]  r3_r    [TOWERS];
  logic signed [H_W-1:0]  h3_r    [TOWERS];
  logic        [SQ_W-1:0] rsq_r   [TOWERS];
  logic        [SQ_W-1:0] hsq_r   [TOWERS];
  logic        [SQ_W-1:0] ytsq_r  [TOWERS];
  logic        [39:0]     lsq_r   [TOWERS];
  logic        [39:0]     usq_r   [TOWERS];

  rdik_job_t job_r;

  assign adv      = !vld_r[3] || !q_full;
  assign in_stall = !adv;
  assign push     = vld_r[3] && !q_full;
  assign job      = job_r;
  assign vld_nxt  = adv ? {vld_r[2:0], in_valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar t = 0; t < TOWERS; t++) begin : g_twr
    logic signed [P_W-1:0]     pxc, pys, pyc, pxs;
    logic signed [S_W-1:0]     xsum, ysum;
    logic signed [23:0]        xt, yt;
    logic signed [63:0]        xr, yr;
    logic signed [2*R_W-1:0]   rr;
    logic signed [2*H_W-1:0]   hh;
    logic signed [47:0]        yy;
    logic        [31:0]        ll, uu;

    assign pxc  = x_coord * twr_cfg[t].cs;
    assign pys  = y_coord * twr_cfg[t].sn;
    assign pyc  = y_coord * twr_cfg[t].cs;
    assign pxs  = x_coord * twr_cfg[t].sn;
    assign xsum = S_W'(pxc_r[t]) + S_W'(pys_r[t]);
    assign ysum = S_W'(pyc_r[t]) - S_W'(pxs_r[t]);
    assign xr   = rnd_shr(64'(xsum), 6'd14);
    assign yr   = rnd_shr(64'(ysum), 6'd14);
    assign xt   = xr[23:0];
    assign yt   = yr[23:0];
    assign rr   = r2_r[t] * r2_r[t];
    assign hh   = h2_r[t] * h2_r[t];
    assign yy   = yt2_r[t] * yt2_r[t];
    assign ll   = twr_cfg[t].rod * twr_cfg[t].rod;
    assign uu   = twr_cfg[t].arm * twr_cfg[t].arm;

    always_ff @(posedge clk) begin
      if (adv) begin
        // stage 1: rotation products
        pxc_r[t] <= pxc;
        pys_r[t] <= pys;
        pyc_r[t] <= pyc;
        pxs_r[t] <= pxs;
        // stage 2: tower-frame offsets
        r2_r[t]  <= $signed({6'd0, radius, 4'd0}) - R_W'(xt);
        h2_r[t]  <= H_W'($signed({twr_cfg[t].bh, 4'd0})) - H_W'(z1_r);
        yt2_r[t] <= yt;
        // stage 3: squares
        r3_r[t]   <= r2_r[t];
        h3_r[t]   <= h2_r[t];
        rsq_r[t]  <= rr[SQ_W-1:0];
        hsq_r[t]  <= SQ_W'(hh);
        ytsq_r[t] <= yy[SQ_W-1:0];
        lsq_r[t]  <= {ll, 8'd0};
        usq_r[t]  <= {uu, 8'd0};
        // stage 4: D and the rod/arm term
        job_r[t].r <= r3_r[t];
        job_r[t].h <= h3_r[t];
        job_r[t].d <= rsq_r[t] + hsq_r[t];
        job_r[t].e <= $signed({8'd0, lsq_r[t]}) - $signed({8'd0, usq_r[t]})
                      - $signed(ytsq_r[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1_r <= z_coord;
    end
  end

endmodule

FILE: rtl/rdik_queue.sv
// Short job queue between the front pipeline and the tower lanes.
module rdik_queue #(
  parameter int DEPTH = rdik_pkg::Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rdik_pkg::rdik_job_t wr_job,
  input  logic                pop,
  output rdik_pkg::rdik_job_t rd_job,
  output logic                full,
  output logic                empty
);
  import rdik_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rdik_job_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/rdik_lane.sv
// One tower lane: sequencer over iterative add/compare steps solving the arm angle.
module rdik_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rdik_pkg::rdik_lane_ctl_t            ctl,
  input  rdik_pkg::rdik_twr_job_t             job,
  input  logic [15:0]                         arm,
  input  logic [15:0]                         spd,
  output rdik_pkg::rdik_lane_sts_t            sts,
  output logic signed [rdik_pkg::STEP_W-1:0]  steps
);
  import rdik_pkg::*;

  localparam logic [4:0] DIV1_LAST = 5'd23;
  localparam logic [4:0] SQ1_LAST  = 5'd23;
  localparam logic [4:0] DIV2_LAST = 5'd30;
  localparam logic [4:0] SQ2_LAST  = 5'd30;
  localparam logic [4:0] CORD_LAST = 5'd29;

  rdik_lane_state_t st_r, st_nxt;
  logic [4:0]       cnt_r;
  logic             unr_r;

  logic signed [R_W-1:0]  r_r;
  logic signed [H_W-1:0]  h_r;
  logic        [SQ_W-1:0] d_r;
  logic signed [E_W-1:0]  e_r;
  logic        [23:0]     num_r;
  logic [61:0]            rem_r, acc_r, bit_r;
  logic                   neg_r;
  logic signed [24:0]     cp_r;
  logic [47:0]            cp2_r;
  logic [24:0]            sq_r;
  logic signed [46:0]     hc_r;
  logic signed [51:0]     rs_r;
  logic [30:0]            smag_r;
  logic signed [33:0]     x_r, y_r;
  logic signed [32:0]     z_r;
  logic signed [62:0]     prod_r;
  logic signed [38:0]     deg_r;
  logic signed [55:0]     sp_r;
  logic signed [STEP_W-1:0] steps_r;

  // combinational helpers
  logic signed [49:0] c_w;
  logic [49:0]        cmag, n_w;
  logic [20:0]        d2u;
  logic               prep_bad;
  logic [22:0]        trial;
  logic               div1_ge;
  logic [48:0]        disc_w;
  logic               disc_bad;
  logic [61:0]        sq_rb;
  logic               sq_ge;
  logic [61:0]        sq_acc;
  logic signed [51:0] n_s;
  logic [51:0]        nm;
  logic               n_bad;
  logic [61:0]        d2_t;
  logic               d2_ge;
  logic [31:0]        s_inc;
  logic [47:0]        cm_sq;
  logic [61:0]        s_sq;
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  logic signed [63:0] deg_w, stp_w;
  logic signed [25:0] sq_s;
  logic               iter_last;

  assign c_w      = 50'(e_r) - $signed({2'd0, d_r});
  assign cmag     = c_w[49] ? 50'(-c_w) : 50'(c_w);
  assign n_w      = cmag + {30'd0, arm, 4'd0};
  assign d2u      = {arm, 5'd0};
  assign prep_bad = (arm == '0) || (d_r == '0) || (n_w[49:24] >= {5'd0, d2u});
  assign trial    = {rem_r[21:0], num_r[23]};
  assign div1_ge  = trial >= {2'd0, d2u};
  assign disc_w   = {1'b0, d_r} - {1'b0, cp2_r};
  assign disc_bad = disc_w[48];
  assign sq_rb    = acc_r + bit_r;
  assign sq_ge    = rem_r >= sq_rb;
  assign sq_acc   = sq_ge ? (acc_r >> 1) + bit_r : acc_r >> 1;
  assign n_s      = 52'(hc_r) - rs_r;
  assign nm       = n_s[51] ? 52'(-n_s) : 52'(n_s);
  assign n_bad    = nm > {4'd0, d_r};
  assign d2_t     = {rem_r[60:0], 1'b0};
  assign d2_ge    = d2_t >= {14'd0, d_r};
  assign s_inc    = {1'b0, acc_r[30:0]} + 32'd1;
  assign cm_sq    = acc_r[23:0] * acc_r[23:0];
  assign s_sq     = smag_r * smag_r;
  assign dx       = y_r >>> cnt_r;
  assign dy       = x_r >>> cnt_r;
  assign at       = $signed({3'd0, atan_q30(cnt_r)});
  assign deg_w    = rnd_shr(64'(prod_r), 6'd24);
  assign stp_w    = rnd_shr(64'(sp_r), 6'd38);
  assign sq_s     = $signed({1'b0, sq_r});

  always_comb begin
    case (st_r)
      L_DIV1:  iter_last = (cnt_r == DIV1_LAST);
      L_SQ1:   iter_last = (cnt_r == SQ1_LAST);
      L_DIV2:  iter_last = (cnt_r == DIV2_LAST);
      L_SQ2:   iter_last = (cnt_r == SQ2_LAST);
      L_CORD:  iter_last = (cnt_r == CORD_LAST);
      default: iter_last = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE:  if (ctl.start) st_nxt = L_PREP;
      L_PREP:  st_nxt = prep_bad ? L_DONE : L_DIV1;
      L_DIV1:  if (iter_last) st_nxt = L_CP;
      L_CP:    st_nxt = L_DISC;
      L_DISC:  st_nxt = disc_bad ? L_DONE : L_SQ1;
      L_SQ1:   if (iter_last) st_nxt = L_SQ1F;
      L_SQ1F:  st_nxt = L_NMUL;
      L_NMUL:  st_nxt = L_NCALC;
      L_NCALC: st_nxt = n_bad ? L_DONE : L_DIV2;
      L_DIV2:  if (iter_last) st_nxt = L_SRND;
      L_SRND:  st_nxt = L_SSQ;
      L_SSQ:   st_nxt = L_SINIT;
      L_SINIT: st_nxt = L_SQ2;
      L_SQ2:   if (iter_last) st_nxt = L_CINIT;
      L_CINIT: st_nxt = L_CORD;
      L_CORD:  if (iter_last) st_nxt = L_DEGM;
      L_DEGM:  st_nxt = L_DEGR;
      L_DEGR:  st_nxt = L_STPM;
      L_STPM:  st_nxt = L_STPR;
      L_STPR:  st_nxt = L_DONE;
      L_DONE:  if (ctl.ack) st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sts.idle    = (st_r == L_IDLE);
    sts.done    = (st_r == L_DONE);
    sts.unreach = unr_r;
    steps       = steps_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      unr_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == L_IDLE && ctl.start) begin
        unr_r <= 1'b0;
      end else if ((st_r == L_PREP && prep_bad) || (st_r == L_DISC && disc_bad) ||
                   (st_r == L_NCALC && n_bad)) begin
        unr_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        if (ctl.start) begin
          r_r <= job.r;
          h_r <= job.h;
          d_r <= job.d;
          e_r <= job.e;
        end
      end
      L_PREP: begin
        rem_r   <= 62'(n_w[49:24]);
        num_r   <= n_w[23:0];
        acc_r   <= '0;
        cnt_r   <= '0;
        neg_r   <= c_w[49];
        if (prep_bad) steps_r <= '0;
      end
      L_DIV1: begin
        rem_r <= 62'(div1_ge ? trial - {2'd0, d2u} : trial);
        acc_r <= {acc_r[60:0], div1_ge};
        num_r <= {num_r[22:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      L_CP: begin
        cp_r  <= neg_r ? -$signed({1'b0, acc_r[23:0]}) : $signed({1'b0, acc_r[23:0]});
        cp2_r <= cm_sq;
      end
      L_DISC: begin
        rem_r <= 62'(disc_w[47:0]);
        acc_r <= '0;
        bit_r <= 62'd1 << 46;
        cnt_r <= '0;
        if (disc_bad) steps_r <= '0;
      end
      L_SQ1, L_SQ2: begin
        if (sq_ge) rem_r <= rem_r - sq_rb;
        acc_r <= sq_acc;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
      end
      L_SQ1F: begin
        sq_r <= acc_r[24:0] + 25'(rem_r > acc_r);
      end
      L_NMUL: begin
        hc_r <= h_r * cp_r;
        rs_r <= r_r * sq_s;
      end
      L_NCALC: begin
        rem_r <= 62'(nm);
        acc_r <= '0;
        neg_r <= n_s[51];
        cnt_r <= '0;
        if (n_bad) steps_r <= '0;
      end
      L_DIV2: begin
        rem_r <= d2_ge ? d2_t - {14'd0, d_r} : d2_t;
        acc_r <= {acc_r[60:0], d2_ge};
        cnt_r <= cnt_r + 5'd1;
      end
      L_SRND: begin
        smag_r <= s_inc[31:1];
      end
      L_SSQ: begin
        rem_r <= s_sq;
      end
      L_SINIT: begin
        rem_r <= (62'd1 << 60) - rem_r;
        acc_r <= '0;
        bit_r <= 62'd1 << 60;
        cnt_r <= '0;
      end
      L_CINIT: begin
        x_r   <= $signed(34'(acc_r[30:0]) + 34'(rem_r > acc_r));
        y_r   <= neg_r ? -$signed({3'd0, smag_r}) : $signed({3'd0, smag_r});
        z_r   <= '0;
        cnt_r <= '0;
      end
      L_CORD: begin
        if (y_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      L_DEGM: begin
        prod_r <= z_r * $signed({1'b0, DEG_PER_RAD_Q24});
      end
      L_DEGR: begin
        deg_r <= deg_w[38:0];
      end
      L_STPM: begin
        sp_r <= deg_r * $signed({1'b0, spd});
      end
      L_STPR: begin
        steps_r <= stp_w[STEP_W-1:0];
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

FILE: rtl/rotary_delta_inverse_kinematics.sv
// Top level of the rotary delta inverse kinematics block.
//
// Usage: write the geometry through the cfg_ port while the block is idle
// (cfg_we with cfg_index 0 radius, 1..3 tower A..C geometry, 4 rod lengths,
// 5 steps per degree; other indexes are dropped). Then present Cartesian
// points on the in_ channel; each accepted beat yields one out_ beat holding
// the three motor positions in steps and a mask of unreachable towers.
// A point passes through the front pipeline, the job queue and the tower lanes,
// which run in parallel. Each lane steps through a 24-step divide, a 24-step
// root, a 31-step divide, a 31-step root and 30 CORDIC rotations. The lanes
// start a new point only once all three are idle again, so they take no new
// point before the last one is collected. Unreachable towers end early, but
// a beat leaves only when all three lanes are done.
// The front keeps accepting beats while the lanes work until the queue and
// the front pipeline are full. When the receiver stalls, the result holds in
// the output register and the lanes hold their finished results.
// Reset (rst_n low at a clock edge) clears the geometry to zero and empties
// the pipeline, the queue and the output register.
module rotary_delta_inverse_kinematics #(
  parameter int QUEUE_DEPTH = rdik_pkg::Q_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rdik_pkg::IN_W-1:0]      in_x_coord,
  input  logic signed [rdik_pkg::IN_W-1:0]      in_y_coord,
  input  logic signed [rdik_pkg::IN_W-1:0]      in_z_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rdik_pkg::STEP_W-1:0]    out_steps_a,
  output logic signed [rdik_pkg::STEP_W-1:0]    out_steps_b,
  output logic signed [rdik_pkg::STEP_W-1:0]    out_steps_c,
  output logic        [rdik_pkg::TOWERS-1:0]    out_unreachable_mask,
  input  logic                                  cfg_we,
  input  logic        [rdik_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rdik_pkg::CFG_W-1:0]     cfg_data
);
  import rdik_pkg::*;

  // configuration registers
  logic [15:0]    radius_r;
  logic [63:0]    geom_r [TOWERS];
  logic [47:0]    rod_r;
  logic [47:0]    spd_r;

  rdik_twr_cfg_all_t twr_cfg;

  // front to queue
  logic      q_push, q_full, q_empty, q_pop;
  rdik_job_t f_job, q_job;

  // lanes
  rdik_lane_ctl_t             lane_ctl;
  rdik_lane_sts_t             lane_sts  [TOWERS];
  logic signed [STEP_W-1:0]   lane_steps [TOWERS];
  logic [TOWERS-1:0]          all_idle_v, all_done_v, unr_v;
  logic                       take;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [STEP_W-1:0]   steps_r [TOWERS];
  logic [TOWERS-1:0]          mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      for (int t = 0; t < TOWERS; t++) begin
        geom_r[t] <= '0;
      end
      rod_r <= '0;
      spd_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius_r  <= cfg_data[15:0];
        REG_GEOM_A: geom_r[0] <= cfg_data;
        REG_GEOM_B: geom_r[1] <= cfg_data;
        REG_GEOM_C: geom_r[2] <= cfg_data;
        REG_ROD:    rod_r     <= cfg_data[47:0];
        REG_SPD:    spd_r     <= cfg_data[47:0];
        default:    radius_r  <= radius_r;
      endcase
    end
  end

  // unpack per-tower geometry
  always_comb begin
    for (int t = 0; t < TOWERS; t++) begin
      twr_cfg[t].cs  = geom_r[t][15:0];
      twr_cfg[t].sn  = geom_r[t][31:16];
      twr_cfg[t].arm = geom_r[t][47:32];
      twr_cfg[t].bh  = geom_r[t][63:48];
      twr_cfg[t].rod = rod_r[16*t +: 16];
      twr_cfg[t].spd = spd_r[16*t +: 16];
    end
  end

  rdik_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_coord  (in_x_coord),
    .y_coord  (in_y_coord),
    .z_coord  (in_z_coord),
    .radius   (radius_r),
    .twr_cfg  (twr_cfg),
    .push     (q_push),
    .job      (f_job),
    .q_full   (q_full)
  );

  rdik_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (f_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // start all lanes together on the queue head; collect when all are done
  always_comb begin
    for (int t = 0; t < TOWERS; t++) begin
      all_idle_v[t] = lane_sts[t].idle;
      all_done_v[t] = lane_sts[t].done;
      unr_v[t]      = lane_sts[t].unreach;
    end
  end

  assign q_pop          = !q_empty && (&all_idle_v);
  assign take           = (&all_done_v) && (!out_valid_r || !out_stall);
  assign lane_ctl.start = q_pop;
  assign lane_ctl.ack   = take;

  for (genvar t = 0; t < TOWERS; t++) begin : g_lane
    rdik_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .job   (q_job[t]),
      .arm   (twr_cfg[t].arm),
      .spd   (twr_cfg[t].spd),
      .sts   (lane_sts[t]),
      .steps (lane_steps[t])
    );
  end

  // output register: load on take, drop once the receiver takes the beat
  assign out_valid_nxt = take ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int t = 0; t < TOWERS; t++) begin
        steps_r[t] <= lane_steps[t];
      end
      mask_r <= unr_v;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_steps_a          = steps_r[0];
  assign out_steps_b          = steps_r[1];
  assign out_steps_c          = steps_r[2];
  assign out_unreachable_mask = mask_r;

  // the front never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // a finished lane 0 stays done until the beat is collected
  a_lane_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_sts[0].done && !take) |=> lane_sts[0].done)
    else $error("lane result lost before collection");

  // an unreachable tower reports zero steps
  a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!mask_r[0] || steps_r[0] == '0) &&
                     (!mask_r[1] || steps_r[1] == '0) &&
                     (!mask_r[2] || steps_r[2] == '0)))
    else $error("unreachable tower with nonzero steps");

endmodule
